/* rtl/bfws_pkg.sv */
// bfws_pkg: constants, payload structs and the internal op type of the
// sliding-window box sum. No dependencies.
package bfws_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_RADIUS = 15;
  localparam int PIXEL_BITS = 16;

  localparam int SPAN_MAX   = 2 * MAX_RADIUS + 1;
  localparam int SIZE_W     = 11;
  localparam int RAD_W      = 4;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int SLOT_W     = $clog2(SPAN_MAX);
  localparam int RS_W       = 21;
  localparam int SUM_W      = 26;
  localparam int LINE_DEPTH = SPAN_MAX * MAX_WIDTH;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);
  localparam int CFG_IDX_W  = 2;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS       = 2'd2;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  typedef struct packed {
    logic                  mode;
    logic [PIXEL_BITS-1:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic [SUM_W-1:0] box_sum;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic             last_in_run;
    logic             last_of_frame;
  } out_item_t;

  // one read-modify-write of a column
  typedef struct packed {
    logic              drain;
    logic [SLOT_W-1:0] slot;
    logic [COL_W-1:0]  col;
    logic [RS_W-1:0]   rs;
    logic              first_row;
    logic              sub_line;
    logic              emit;
    logic [ROW_W-1:0]  row;
    logic              last_in_run;
    logic              last_of_frame;
  } op_t;

endpackage

/* rtl/box_filter_window_sum.sv */
// box_filter_window_sum: top level, pixel front end and configuration.
// Depends on bfws_pkg and bfws_sum_stage.
//
// Streaming (2r+1) x (2r+1) box sum with zero outside the frame. While the
// result queue has space, a pixel transfer is taken every cycle; the last
// pixel of each row is followed by a stall while the right-border columns are
// issued, one column per cycle. Every column update is a read-modify-write of
// the line store and the column sum memory (registered read, write in the
// next cycle, forwarded), so the memory port sets the rate of one column per
// cycle. After the frame each flush transfer yields one result of the bottom
// min(r, height) rows. Width, height and radius are sampled at the first pixel
// of each frame. Results wait in a four-entry queue, so input keeps flowing
// while the output stalls until that queue fills.
module box_filter_window_sum import bfws_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data
);

  logic [SIZE_W-1:0] cfg_width, cfg_height;
  logic [RAD_W-1:0]  cfg_radius;
  logic [SIZE_W-1:0] geo_w, geo_h;
  logic [RAD_W-1:0]  geo_r;

  logic [ROW_W-1:0]      in_row;
  logic [COL_W-1:0]      in_col;
  logic [SLOT_W-1:0]     in_slot;
  logic [RS_W-1:0]       rs;
  logic [PIXEL_BITS-1:0] recent [0:SPAN_MAX-1];

  logic              bursting;
  logic [COL_W-1:0]  burst_col;
  logic [ROW_W-1:0]  burst_row;
  logic [SLOT_W-1:0] burst_slot;

  logic              drain_pending;
  logic [ROW_W-1:0]  drain_row;
  logic [COL_W-1:0]  drain_col;
  logic [SLOT_W-1:0] drain_slot;

  logic              frame_start;
  logic [SIZE_W-1:0] cur_w, cur_h;
  logic [RAD_W-1:0]  cur_r;
  logic [SLOT_W-1:0] span_p, span_g;
  logic [COL_W-1:0]  x;
  logic [ROW_W-1:0]  y;
  logic [SLOT_W-1:0] slot;
  logic              row_end, last_row, main_ok, burst_empty;
  logic [SLOT_W-1:0] rd_idx;
  logic [PIXEL_BITS-1:0] rec_out;
  logic [RS_W-1:0]   rs_px, rs_b;
  logic              burst_sub, burst_last;
  logic              drain_last_col, drain_lof;
  logic [SIZE_W-1:0] rows;
  logic [SLOT_W:0]   dslot_tmp;
  logic [SLOT_W-1:0] dslot_init;

  logic space, accept, px_acc, fl_acc, burst_go, op_valid;
  op_t  op;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input logic [SIZE_W-1:0] mx);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > mx) begin
      r = mx;
    end
    return r;
  endfunction

  assign frame_start = drain_pending || (in_row == '0 && in_col == '0);
  assign cur_w  = frame_start ? clamp_size(cfg_width, SIZE_W'(MAX_WIDTH)) : geo_w;
  assign cur_h  = frame_start ? clamp_size(cfg_height, SIZE_W'(MAX_HEIGHT)) : geo_h;
  assign cur_r  = frame_start ? cfg_radius : geo_r;
  assign span_p = {cur_r, 1'b1};
  assign span_g = {geo_r, 1'b1};
  assign x      = frame_start ? '0 : in_col;
  assign y      = frame_start ? '0 : in_row;
  assign slot   = frame_start ? '0 : in_slot;

  assign row_end     = (SIZE_W'(x) + SIZE_W'(1)) == cur_w;
  assign last_row    = (SIZE_W'(y) + SIZE_W'(1)) == cur_h;
  assign main_ok     = x >= COL_W'(cur_r);
  assign burst_empty = (cur_r == '0);

  // one read port on the pixel history: oldest tap for a pixel, border tap in a burst
  assign rd_idx  = bursting ? SLOT_W'(geo_w + SIZE_W'(geo_r) - SIZE_W'(burst_col))
                            : {cur_r, 1'b0};
  assign rec_out = recent[rd_idx];

  assign rs_px = (x == '0 ? '0 : rs) + RS_W'(in_data.pixel)
                 - ((SIZE_W'(x) >= SIZE_W'(span_p)) ? RS_W'(rec_out) : '0);

  assign burst_sub  = burst_col > COL_W'(geo_r);
  assign rs_b       = rs - (burst_sub ? RS_W'(rec_out) : '0);
  assign burst_last = (SIZE_W'(burst_col) + SIZE_W'(1)) == geo_w;

  assign drain_last_col = (SIZE_W'(drain_col) + SIZE_W'(1)) == geo_w;
  assign drain_lof      = drain_last_col && ((SIZE_W'(drain_row) + SIZE_W'(1)) == geo_h);

  // drain starts at the slot r + rows rows above the last row
  assign rows       = (SIZE_W'(cur_r) < cur_h) ? SIZE_W'(cur_r) : cur_h;
  assign dslot_tmp  = (SLOT_W + 1)'(slot) + (SLOT_W + 1)'(span_p)
                      - (SLOT_W + 1)'(rows) - (SLOT_W + 1)'(cur_r);
  assign dslot_init = (dslot_tmp >= (SLOT_W + 1)'(span_p))
                      ? SLOT_W'(dslot_tmp - (SLOT_W + 1)'(span_p)) : SLOT_W'(dslot_tmp);

  assign in_ready = !bursting && space;
  assign accept   = in_valid && in_ready;
  assign px_acc   = accept && (in_data.mode == MODE_PIXEL);
  assign fl_acc   = accept && (in_data.mode == MODE_FLUSH) && drain_pending;
  assign burst_go = bursting && space;
  assign op_valid = (px_acc && main_ok) || fl_acc || burst_go;

  always_comb begin
    op = '0;
    if (burst_go) begin
      op.slot        = burst_slot;
      op.col         = burst_col;
      op.rs          = rs_b;
      op.first_row   = (burst_row == '0);
      op.sub_line    = SIZE_W'(burst_row) >= SIZE_W'(span_g);
      op.emit        = burst_row >= ROW_W'(geo_r);
      op.row         = burst_row - ROW_W'(geo_r);
      op.last_in_run = burst_last;
    end else if (in_data.mode == MODE_FLUSH) begin
      op.drain         = 1'b1;
      op.slot          = drain_slot;
      op.col           = drain_col;
      op.sub_line      = drain_row > ROW_W'(geo_r);
      op.emit          = 1'b1;
      op.row           = drain_row;
      op.last_in_run   = 1'b1;
      op.last_of_frame = drain_lof;
    end else begin
      op.slot          = slot;
      op.col           = x - COL_W'(cur_r);
      op.rs            = rs_px;
      op.first_row     = (y == '0);
      op.sub_line      = SIZE_W'(y) >= SIZE_W'(span_p);
      op.emit          = y >= ROW_W'(cur_r);
      op.row           = y - ROW_W'(cur_r);
      op.last_in_run   = !row_end || burst_empty;
      op.last_of_frame = row_end && last_row && burst_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (px_acc) begin
      recent[0] <= in_data.pixel;
      for (int i = 1; i < SPAN_MAX; i++) begin
        recent[i] <= recent[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width     <= SIZE_W'(640);
      cfg_height    <= SIZE_W'(480);
      cfg_radius    <= RAD_W'(1);
      geo_w         <= SIZE_W'(640);
      geo_h         <= SIZE_W'(480);
      geo_r         <= RAD_W'(1);
      in_row        <= '0;
      in_col        <= '0;
      in_slot       <= '0;
      rs            <= '0;
      bursting      <= 1'b0;
      burst_col     <= '0;
      burst_row     <= '0;
      burst_slot    <= '0;
      drain_pending <= 1'b0;
      drain_row     <= '0;
      drain_col     <= '0;
      drain_slot    <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_FRAME_WIDTH:  cfg_width  <= cfg_data;
          CFG_FRAME_HEIGHT: cfg_height <= cfg_data;
          CFG_RADIUS:       cfg_radius <= cfg_data[RAD_W-1:0];
          default: ;
        endcase
      end

      if (px_acc) begin
        geo_w         <= cur_w;
        geo_h         <= cur_h;
        geo_r         <= cur_r;
        rs            <= rs_px;
        drain_pending <= 1'b0;
        if (row_end) begin
          in_col <= '0;
          if (!burst_empty) begin
            bursting   <= 1'b1;
            burst_col  <= (cur_w > SIZE_W'(cur_r)) ? COL_W'(cur_w - SIZE_W'(cur_r)) : '0;
            burst_row  <= y;
            burst_slot <= slot;
          end
          if (last_row) begin
            in_row  <= '0;
            in_slot <= '0;
            if (!burst_empty) begin
              drain_pending <= 1'b1;
              drain_row     <= ROW_W'(cur_h - rows);
              drain_col     <= '0;
              drain_slot    <= dslot_init;
            end
          end else begin
            in_row  <= y + 1'b1;
            in_slot <= (slot == span_p - 1'b1) ? '0 : slot + 1'b1;
          end
        end else begin
          in_col  <= x + 1'b1;
          in_row  <= y;
          in_slot <= slot;
        end
      end

      if (burst_go) begin
        rs        <= rs_b;
        burst_col <= burst_col + 1'b1;
        if (burst_last) begin
          bursting <= 1'b0;
        end
      end

      if (fl_acc) begin
        if (drain_lof) begin
          drain_pending <= 1'b0;
        end else if (drain_last_col) begin
          drain_col  <= '0;
          drain_row  <= drain_row + 1'b1;
          drain_slot <= (drain_slot == span_g - 1'b1) ? '0 : drain_slot + 1'b1;
        end else begin
          drain_col <= drain_col + 1'b1;
        end
      end
    end
  end

  bfws_sum_stage u_sum (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op        (op),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* rtl/bfws_sum_stage.sv */
// bfws_sum_stage: line store and column sum memories, the read-modify-write
// stage with forwarding, and the result queue. Depends on bfws_pkg.
module bfws_sum_stage import bfws_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      op_valid,
  input  op_t       op,
  output logic      space,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic [RS_W-1:0]  line_mem [0:LINE_DEPTH-1];
  logic [SUM_W-1:0] col_mem  [0:MAX_WIDTH-1];

  logic             b_valid;
  op_t              b_op;
  logic [RS_W-1:0]  line_rd;
  logic [SUM_W-1:0] col_rd;

  logic               fw_col_valid;
  logic [COL_W-1:0]   fw_col;
  logic [SUM_W-1:0]   fw_col_val;
  logic               fw_line_valid;
  logic [LINE_AW-1:0] fw_addr;
  logic [RS_W-1:0]    fw_line_val;

  logic [LINE_AW-1:0] a_addr;
  logic [LINE_AW-1:0] b_addr;
  logic [SUM_W-1:0]   col_old;
  logic [RS_W-1:0]    line_old;
  logic [SUM_W-1:0]   line_sub;
  logic [SUM_W-1:0]   col_new;

  out_item_t          fifo [0:FIFO_DEPTH-1];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_CW-1:0] count;
  logic               push;
  logic               pop;
  out_item_t          push_item;

  assign a_addr = LINE_AW'({op.slot, op.col});
  assign b_addr = LINE_AW'({b_op.slot, b_op.col});

  // memories: read in the issue cycle, written back in the next cycle
  always_ff @(posedge clk) begin
    if (op_valid) begin
      line_rd <= line_mem[a_addr];
      col_rd  <= col_mem[op.col];
    end
    if (b_valid) begin
      col_mem[b_op.col] <= col_new;
      if (!b_op.drain) begin
        line_mem[b_addr] <= b_op.rs;
      end
    end
  end

  always_ff @(posedge clk) begin
    b_op        <= op;
    fw_col      <= b_op.col;
    fw_col_val  <= col_new;
    fw_addr     <= b_addr;
    fw_line_val <= b_op.rs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid       <= 1'b0;
      fw_col_valid  <= 1'b0;
      fw_line_valid <= 1'b0;
    end else begin
      b_valid       <= op_valid;
      fw_col_valid  <= b_valid;
      fw_line_valid <= b_valid && !b_op.drain;
    end
  end

  // the write of the previous cycle is not yet visible to this read
  always_comb begin
    col_old  = (fw_col_valid && fw_col == b_op.col) ? fw_col_val : col_rd;
    line_old = (fw_line_valid && fw_addr == b_addr) ? fw_line_val : line_rd;
    line_sub = b_op.sub_line ? SUM_W'(line_old) : '0;
    if (b_op.drain) begin
      col_new = col_old - line_sub;
    end else begin
      col_new = (b_op.first_row ? '0 : col_old) + SUM_W'(b_op.rs) - line_sub;
    end
  end

  always_comb begin
    push_item.box_sum       = col_new;
    push_item.out_row       = b_op.row;
    push_item.out_col       = b_op.col;
    push_item.last_in_run   = b_op.last_in_run;
    push_item.last_of_frame = b_op.last_of_frame;
  end

  assign push      = b_valid && b_op.emit;
  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign out_data  = fifo[rd_ptr];
  assign space     = ((FIFO_CW + 1)'(count) + (FIFO_CW + 1)'(b_valid))
                     < (FIFO_CW + 1)'(FIFO_DEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + FIFO_CW'(push) - FIFO_CW'(pop);
    end
  end

endmodule
